@@ rtl/dra_pkg.sv @@
// ----------------------------------------------------------------------------
// dra_pkg
// Shared types, widths and codes for the descriptor range allocator.
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam int MAX_SPANS_DEF = 64;
  localparam int MAX_SLOTS     = 65536;

  localparam int SLOT_W = 16;
  localparam int LEN_W  = 17;
  localparam int ADDR_W = 48;
  localparam int INC_W  = 13;
  localparam int STAT_W = 3;
  localparam int REG_W  = 2;
  localparam int DCNT_W = $clog2(ADDR_W);
  localparam int PROD_W = INC_W + SLOT_W;

  localparam logic [LEN_W-1:0] HEAP_RESET = LEN_W'(MAX_SLOTS);
  localparam logic [INC_W-1:0] INC_RESET  = INC_W'(32);

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOFIT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd4;

  localparam logic [REG_W-1:0] REG_HEAP_SIZE = 2'd0;
  localparam logic [REG_W-1:0] REG_CPU_BASE  = 2'd1;
  localparam logic [REG_W-1:0] REG_GPU_BASE  = 2'd2;
  localparam logic [REG_W-1:0] REG_INCREMENT = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;

  typedef struct packed {
    logic [SLOT_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } span_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_A_RD, S_A_CHK, S_RM_RD, S_RM_WR, S_MUL, S_ADD,
    S_DIV, S_R_CHK, S_R_RD, S_R_CMP,
    S_B_START, S_B_LOAD, S_B_RD, S_B_CMP,
    S_C_START, S_C_LOAD, S_C_RD, S_C_CMP,
    S_FIN
  } state_t;

endpackage

@@ rtl/descriptor_range_allocator_core.sv @@
// ----------------------------------------------------------------------------
// descriptor_range_allocator_core
// Free-span range allocator for a descriptor heap with release coalescing.
// ----------------------------------------------------------------------------
// One transaction is worked at a time through a simple dual-port span memory
// (one read, one write per cycle, registered read data). An allocate walks the
// spans from the newest back, shifts the later spans down when a span empties,
// and then does the address multiply and add. A release runs a bit-serial
// handle divide and searches the spans. When it merges, it bubble-sorts the
// list by start (passes repeat until none swaps) and then runs a coalesce pass.
// The next transaction is accepted while a finished result waits at the
// output. After reset, the S_INIT state loads the initial span.
// ----------------------------------------------------------------------------
module descriptor_range_allocator_core #(
  parameter int MAX_SPANS = dra_pkg::MAX_SPANS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dra_pkg::REG_W-1:0]   cfg_index,
  input  logic [dra_pkg::ADDR_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [dra_pkg::LEN_W-1:0]   block_size,
  input  logic [dra_pkg::ADDR_W-1:0]  handle_address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dra_pkg::STAT_W-1:0]  status,
  output logic [dra_pkg::SLOT_W-1:0]  slot_index,
  output logic [dra_pkg::ADDR_W-1:0]  cpu_address,
  output logic [dra_pkg::ADDR_W-1:0]  gpu_address
);
  import dra_pkg::*;

  localparam int CNT_W = $clog2(MAX_SPANS + 1);
  localparam int IDX_W = $clog2(MAX_SPANS);

  state_t state, state_next;

  logic [LEN_W-1:0]  heap_size;
  logic [ADDR_W-1:0] cpu_base;
  logic [ADDR_W-1:0] gpu_base;
  logic [INC_W-1:0]  increment;

  span_t mem [MAX_SPANS];
  span_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  span_t            mem_wdata;

  logic [CNT_W-1:0] count, ptr, wptr, ptr_p1, ptr_m1, cnt_m1;
  logic [LEN_W-1:0] op_size;
  span_t            hold, cur;
  logic             swapped;

  logic [ADDR_W-1:0] q;
  logic [INC_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;
  logic [PROD_W-1:0] prod;

  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [ADDR_W-1:0] res_cpu, res_gpu;

  logic [INC_W-1:0]  inc_eff;
  logic [INC_W:0]    rem_sh;
  logic              div_ge;
  logic [LEN_W-1:0]  heap_sat;
  logic              heap_wr, fits, match, outside, full, greater, adj, fin_go;
  logic [LEN_W-1:0]  newlen;

  assign ptr_p1   = ptr + 1'b1;
  assign ptr_m1   = ptr - 1'b1;
  assign cnt_m1   = count - 1'b1;
  assign inc_eff  = (increment == '0) ? INC_W'(1) : increment;
  assign rem_sh   = {rem, q[ADDR_W-1]};
  assign div_ge   = rem_sh >= {1'b0, inc_eff};
  assign heap_sat = (cfg_data[LEN_W-1:0] > LEN_W'(MAX_SLOTS)) ? LEN_W'(MAX_SLOTS)
                                                               : cfg_data[LEN_W-1:0];
  assign heap_wr  = cfg_we && (cfg_index == REG_HEAP_SIZE);
  assign fits     = rd_data.len >= op_size;
  assign newlen   = rd_data.len - op_size;
  assign match    = (ADDR_W'(rd_data.start) + ADDR_W'(rd_data.len)) == q;
  assign outside  = ({1'b0, q} + (ADDR_W+1)'(op_size)) > (ADDR_W+1)'(heap_size);
  assign full     = count == CNT_W'(MAX_SPANS);
  assign greater  = hold.start > rd_data.start;
  assign adj      = ((LEN_W+1)'(cur.start) + (LEN_W+1)'(cur.len)) ==
                    (LEN_W+1)'(rd_data.start);
  assign fin_go   = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_size <= HEAP_RESET;
      cpu_base  <= '0;
      gpu_base  <= '0;
      increment <= INC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAP_SIZE: heap_size <= heap_sat;
        REG_CPU_BASE:  cpu_base  <= cfg_data;
        REG_GPU_BASE:  gpu_base  <= cfg_data;
        REG_INCREMENT: increment <= cfg_data[INC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    rd_addr    = '0;
    case (state)
      S_INIT: begin
        mem_we     = 1'b1;
        mem_wdata  = '{start: '0, len: heap_size};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (block_size == '0)      state_next = S_FIN;
          else if (kind == KIND_ALLOC) state_next = S_A_RD;
          else                       state_next = S_DIV;
        end
      end
      S_A_RD: begin
        if (ptr == '0) begin
          state_next = S_FIN;
        end else begin
          rd_addr    = ptr_m1[IDX_W-1:0];
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (fits) begin
          if (newlen == '0) begin
            state_next = S_RM_RD;
          end else begin
            mem_we     = 1'b1;
            mem_waddr  = ptr[IDX_W-1:0];
            mem_wdata  = '{start: rd_data.start, len: newlen};
            state_next = S_MUL;
          end
        end else begin
          state_next = S_A_RD;
        end
      end
      S_RM_RD: begin
        if (ptr_p1 < count) begin
          rd_addr    = ptr_p1[IDX_W-1:0];
          state_next = S_RM_WR;
        end else begin
          state_next = S_MUL;
        end
      end
      S_RM_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr[IDX_W-1:0];
        mem_wdata  = rd_data;
        state_next = S_RM_RD;
      end
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = S_FIN;
      S_DIV: begin
        if (dcnt == '0) state_next = S_R_CHK;
      end
      S_R_CHK: state_next = outside ? S_FIN : S_R_RD;
      S_R_RD: begin
        if (ptr == count) begin
          if (!full) begin
            mem_we    = 1'b1;
            mem_waddr = count[IDX_W-1:0];
            mem_wdata = '{start: q[SLOT_W-1:0], len: op_size};
          end
          state_next = S_FIN;
        end else begin
          rd_addr    = ptr[IDX_W-1:0];
          state_next = S_R_CMP;
        end
      end
      S_R_CMP: begin
        if (match) begin
          mem_we     = 1'b1;
          mem_waddr  = ptr[IDX_W-1:0];
          mem_wdata  = '{start: rd_data.start, len: rd_data.len + op_size};
          state_next = (count > CNT_W'(1)) ? S_B_START : S_FIN;
        end else begin
          state_next = S_R_RD;
        end
      end
      S_B_START: state_next = S_B_LOAD;
      S_B_LOAD:  state_next = S_B_RD;
      S_B_RD: begin
        if (ptr == count) begin
          mem_we     = 1'b1;
          mem_waddr  = cnt_m1[IDX_W-1:0];
          mem_wdata  = hold;
          state_next = swapped ? S_B_START : S_C_START;
        end else begin
          rd_addr    = ptr[IDX_W-1:0];
          state_next = S_B_CMP;
        end
      end
      S_B_CMP: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr_m1[IDX_W-1:0];
        mem_wdata  = greater ? rd_data : hold;
        state_next = S_B_RD;
      end
      S_C_START: state_next = S_C_LOAD;
      S_C_LOAD:  state_next = S_C_RD;
      S_C_RD: begin
        if (ptr == count) begin
          mem_we     = 1'b1;
          mem_waddr  = wptr[IDX_W-1:0];
          mem_wdata  = cur;
          state_next = S_FIN;
        end else begin
          rd_addr    = ptr[IDX_W-1:0];
          state_next = S_C_CMP;
        end
      end
      S_C_CMP: begin
        if (!adj) begin
          mem_we    = 1'b1;
          mem_waddr = wptr[IDX_W-1:0];
          mem_wdata = cur;
        end
        state_next = S_C_RD;
      end
      S_FIN: begin
        if (fin_go) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (heap_wr) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '{start: '0, len: heap_sat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
    end else if (heap_wr) begin
      count <= (heap_sat != '0) ? CNT_W'(1) : '0;
    end else begin
      case (state)
        S_RM_RD: if (!(ptr_p1 < count)) count <= cnt_m1;
        S_R_RD:  if (ptr == count && !full) count <= count + 1'b1;
        S_C_RD:  if (ptr == count) count <= wptr + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_size    <= block_size;
        res_status <= (block_size == '0) ? ST_ZERO : ST_OK;
        res_slot   <= '0;
        res_cpu    <= '0;
        res_gpu    <= '0;
        ptr        <= count;
        q          <= handle_address - cpu_base;
        rem        <= '0;
        dcnt       <= DCNT_W'(ADDR_W - 1);
      end
      S_A_RD: begin
        if (ptr == '0) res_status <= ST_NOFIT;
        else           ptr <= ptr_m1;
      end
      S_A_CHK: begin
        if (fits) res_slot <= rd_data.start + newlen[SLOT_W-1:0];
      end
      S_RM_WR: ptr <= ptr_p1;
      S_MUL:   prod <= PROD_W'(inc_eff) * PROD_W'(res_slot);
      S_ADD: begin
        res_cpu <= cpu_base + ADDR_W'(prod);
        res_gpu <= gpu_base + ADDR_W'(prod);
      end
      S_DIV: begin
        rem  <= div_ge ? INC_W'(rem_sh - {1'b0, inc_eff}) : rem_sh[INC_W-1:0];
        q    <= {q[ADDR_W-2:0], div_ge};
        dcnt <= dcnt - 1'b1;
      end
      S_R_CHK: begin
        if (outside) begin
          res_status <= ST_OUTSIDE;
        end else begin
          ptr      <= '0;
          res_slot <= q[SLOT_W-1:0];
        end
      end
      S_R_RD: begin
        if (ptr == count && full) begin
          res_status <= ST_FULL;
          res_slot   <= '0;
        end
      end
      S_R_CMP: begin
        if (!match) ptr <= ptr_p1;
      end
      S_B_START: begin
        ptr     <= CNT_W'(1);
        swapped <= 1'b0;
      end
      S_B_LOAD: hold <= rd_data;
      S_B_CMP: begin
        if (greater) swapped <= 1'b1;
        else         hold <= rd_data;
        ptr <= ptr_p1;
      end
      S_C_START: begin
        ptr  <= CNT_W'(1);
        wptr <= '0;
      end
      S_C_LOAD: cur <= rd_data;
      S_C_CMP: begin
        if (adj) begin
          cur.len <= cur.len + rd_data.len;
        end else begin
          cur  <= rd_data;
          wptr <= wptr + 1'b1;
        end
        ptr <= ptr_p1;
      end
      S_FIN: begin
        if (fin_go) begin
          status      <= res_status;
          slot_index  <= res_slot;
          cpu_address <= res_cpu;
          gpu_address <= res_gpu;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst)                       out_valid <= 1'b0;
    else if (state == S_FIN && fin_go) out_valid <= 1'b1;
    else if (out_ready)            out_valid <= 1'b0;
  end

endmodule

@@ rtl/dra_checker.sv @@
// ----------------------------------------------------------------------------
// dra_checker
// Port-level checks for the descriptor range allocator.
// ----------------------------------------------------------------------------
module dra_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dra_pkg::STAT_W-1:0]  status,
  input logic [dra_pkg::SLOT_W-1:0]  slot_index,
  input logic [dra_pkg::ADDR_W-1:0]  cpu_address,
  input logic [dra_pkg::ADDR_W-1:0]  gpu_address
);
  import dra_pkg::*;

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |->
      slot_index == '0 && cpu_address == '0 && gpu_address == '0)
    else $error("error result carries nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_OUTSIDE)
    else $error("status code out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a transaction");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index))
    else $error("stalled result changed");

endmodule

bind descriptor_range_allocator_core dra_checker u_dra_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for descriptor_range_allocator_core. A behavioral
// free-span model predicts every response. Directed tests cover the field
// extremes, the error codes, a full span list and register extremes.
// Random phases then run alloc/release traffic with random bases, strides
// and heap sizes, under random idling and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import dra_pkg::*;

  localparam int NSPANS = 64;
  localparam longint unsigned MASK48 = 48'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 60000000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] ca;
    logic [ADDR_W-1:0] ga;
  } resp_t;

  typedef struct {
    int unsigned first;
    int unsigned size;
  } block_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [LEN_W-1:0] block_size = '0;
  logic [ADDR_W-1:0] handle_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_index;
  logic [ADDR_W-1:0] cpu_address;
  logic [ADDR_W-1:0] gpu_address;

  descriptor_range_allocator_core dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // free-list model state
  int unsigned fl_start[NSPANS];
  int unsigned fl_len[NSPANS];
  int unsigned fl_count;
  int unsigned m_heap;
  longint unsigned m_cpu, m_gpu;
  int unsigned m_inc;

  resp_t pending[$];
  block_t live_blocks[$];
  int errors = 0;
  bit no_idle = 1'b0;
  int hold_cycles = 0;
  int cycles = 0;

  function automatic longint unsigned stride();
    return (m_inc == 0) ? 64'd1 : longint'(m_inc);
  endfunction

  function automatic void reset_list();
    for (int i = 0; i < NSPANS; i++) begin
      fl_start[i] = 0;
      fl_len[i] = 0;
    end
    fl_len[0] = m_heap;
    fl_count = (m_heap != 0) ? 1 : 0;
  endfunction

  function automatic void drop_span(int unsigned at);
    for (int unsigned i = at; i + 1 < fl_count; i++) begin
      fl_start[i] = fl_start[i+1];
      fl_len[i] = fl_len[i+1];
    end
    fl_count--;
  endfunction

  function automatic void sort_merge_spans();
    int unsigned s, l, j, i;
    for (i = 1; i < fl_count; i++) begin
      s = fl_start[i];
      l = fl_len[i];
      j = i;
      while (j > 0 && fl_start[j-1] > s) begin
        fl_start[j] = fl_start[j-1];
        fl_len[j] = fl_len[j-1];
        j--;
      end
      fl_start[j] = s;
      fl_len[j] = l;
    end
    i = 1;
    while (i < fl_count) begin
      if (fl_start[i-1] + fl_len[i-1] == fl_start[i]) begin
        fl_len[i-1] += fl_len[i];
        drop_span(i);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic resp_t predict_response(logic k, int unsigned size, longint unsigned addr);
    resp_t r;
    int k_at;
    bit hit;
    longint unsigned idx;
    r = '0;
    r.status = ST_OK;
    if (size == 0) begin
      r.status = ST_ZERO;
    end else if (k == KIND_ALLOC) begin
      k_at = -1;
      for (int i = int'(fl_count) - 1; i >= 0; i--) begin
        if (fl_len[i] >= size) begin
          k_at = i;
          break;
        end
      end
      if (k_at < 0) begin
        r.status = ST_NOFIT;
      end else begin
        fl_len[k_at] -= size;
        r.slot = SLOT_W'(fl_start[k_at] + fl_len[k_at]);
        idx = fl_start[k_at] + fl_len[k_at];
        if (fl_len[k_at] == 0) drop_span(k_at);
        r.ca = ADDR_W'((m_cpu + stride() * idx) & MASK48);
        r.ga = ADDR_W'((m_gpu + stride() * idx) & MASK48);
      end
    end else begin
      idx = ((addr - m_cpu) & MASK48) / stride();
      if (idx + size > m_heap) begin
        r.status = ST_OUTSIDE;
      end else begin
        hit = 1'b0;
        for (int unsigned i = 0; i < fl_count; i++) begin
          if (longint'(fl_start[i]) + fl_len[i] == idx) begin
            fl_len[i] += size;
            hit = 1'b1;
            break;
          end
        end
        if (hit) begin
          sort_merge_spans();
          r.slot = SLOT_W'(idx);
        end else if (fl_count >= NSPANS) begin
          r.status = ST_FULL;
        end else begin
          fl_start[fl_count] = int'(idx);
          fl_len[fl_count] = size;
          fl_count++;
          r.slot = SLOT_W'(idx);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready = 1'b0;
    end else begin
      out_ready = no_idle || ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response status=%0d slot=%0d", status, slot_index);
      end else begin
        e = pending.pop_front();
        if (status !== e.status || slot_index !== e.slot ||
            cpu_address !== e.ca || gpu_address !== e.ga) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d slot=%0d ca=%h ga=%h got st=%0d slot=%0d ca=%h ga=%h",
                     e.status, e.slot, e.ca, e.ga, status, slot_index, cpu_address, gpu_address);
        end
      end
    end
  end

  task automatic send_request(logic k, int unsigned size, longint unsigned addr);
    resp_t r;
    if (!no_idle && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    kind = k;
    block_size = LEN_W'(size);
    handle_address = ADDR_W'(addr);
    in_valid = 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    r = predict_response(k, size & 32'h1FFFF, addr & MASK48);
    pending.push_back(r);
    if (k == KIND_ALLOC && r.status == ST_OK) live_blocks.push_back('{r.slot, size});
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    wait (pending.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_W-1:0] idx, longint unsigned value);
    drain();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = ADDR_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_HEAP_SIZE: begin
        m_heap = ((value & 32'h1FFFF) > MAX_SLOTS) ? MAX_SLOTS : (value & 32'h1FFFF);
        reset_list();
        live_blocks.delete();
      end
      REG_CPU_BASE: m_cpu = value & MASK48;
      REG_GPU_BASE: m_gpu = value & MASK48;
      REG_INCREMENT: m_inc = value & 32'h1FFF;
      default: ;
    endcase
  endtask

  task automatic free_block(int unsigned first, int unsigned size);
    send_request(~KIND_ALLOC, size, m_cpu + stride() * first + $urandom_range(int'(stride()) - 1));
  endtask

  task automatic test_defaults();
    send_request(KIND_ALLOC, 0, 0);
    send_request(~KIND_ALLOC, 0, 48'hFFFF_FFFF_FFFF);
    send_request(KIND_ALLOC, 65536, 48'h1234);
    send_request(KIND_ALLOC, 1, 0);
    send_request(~KIND_ALLOC, 65536, 0);
    send_request(KIND_ALLOC, 131071, 0);
    send_request(~KIND_ALLOC, 1, 48'hFFFF_FFFF_FFFF);
    send_request(KIND_ALLOC, 100, 0);
    send_request(~KIND_ALLOC, 100, 32 * (65536 - 100) + 31);
    live_blocks.delete();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_HEAP_SIZE, 0);
    send_request(KIND_ALLOC, 1, 0);
    send_request(~KIND_ALLOC, 1, 0);
    write_reg(REG_HEAP_SIZE, 131071);
    write_reg(REG_INCREMENT, 0);
    write_reg(REG_CPU_BASE, MASK48);
    write_reg(REG_GPU_BASE, MASK48);
    send_request(KIND_ALLOC, 1, 0);
    send_request(~KIND_ALLOC, 1, MASK48 + 65535);
    write_reg(REG_INCREMENT, 8191);
    send_request(KIND_ALLOC, 7, 0);
    write_reg(REG_INCREMENT, 4096);
    send_request(KIND_ALLOC, 1, 0);
    write_reg(REG_HEAP_SIZE, 1);
    send_request(KIND_ALLOC, 1, 0);
    send_request(KIND_ALLOC, 1, 0);
    send_request(~KIND_ALLOC, 2, MASK48);
    send_request(~KIND_ALLOC, 1, MASK48);
  endtask

  task automatic test_list_full();
    write_reg(REG_HEAP_SIZE, 256);
    write_reg(REG_INCREMENT, 1);
    write_reg(REG_CPU_BASE, 0);
    send_request(KIND_ALLOC, 128, 0);
    for (int i = 0; i < 64; i++) send_request(~KIND_ALLOC, 1, 130 + 2 * i);
    send_request(~KIND_ALLOC, 1, 128);
    send_request(~KIND_ALLOC, 1, 129);
  endtask

  task automatic test_backpressure();
    write_reg(REG_HEAP_SIZE, 512);
    write_reg(REG_INCREMENT, 16);
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_request(KIND_ALLOC, $urandom_range(8, 1), 0);
    drain();
    for (int i = 0; i < 10; i++) send_request(KIND_ALLOC, $urandom_range(8, 1), 0);
    drain();
  endtask

  task automatic test_random_traffic();
    block_t b;
    int pick, sel;
    for (int phase = 0; phase < 7; phase++) begin
      write_reg(REG_CPU_BASE, {$urandom, $urandom} & MASK48);
      write_reg(REG_GPU_BASE, {$urandom, $urandom} & MASK48);
      sel = $urandom_range(5);
      write_reg(REG_INCREMENT, sel == 0 ? 0 : sel == 1 ? 8191 : $urandom_range(4096, 1));
      write_reg(REG_HEAP_SIZE, phase == 3 ? 65536 : $urandom_range(256, 8));
      no_idle = (phase == 2);
      for (int n = 0; n < 200; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_request(KIND_ALLOC, $urandom_range(16, 1), {$urandom, $urandom});
        end else if (pick < 92 && live_blocks.size() > 0) begin
          sel = $urandom_range(live_blocks.size() - 1);
          b = live_blocks[sel];
          live_blocks.delete(sel);
          free_block(b.first, b.size);
        end else begin
          send_request($urandom_range(1), $urandom_range(1) ? $urandom_range(131071) : 0,
                       {$urandom, $urandom});
        end
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    m_heap = MAX_SLOTS;
    m_cpu = 0;
    m_gpu = 0;
    m_inc = 32;
    reset_list();
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_defaults();
    test_register_extremes();
    test_list_full();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
